@@ hw/rtl/xsbc_pkg.sv @@
package xsbc_pkg;

  localparam int KEY_DEPTH   = 128;
  localparam int ROUND_COUNT = 5;

  localparam int BYTE_W   = 8;
  localparam int TBL_AW   = 8;
  localparam int TBL_DEPTH = 1 << TBL_AW;
  localparam int POS_W    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int RND_W    = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam int KEY_WORDS = ROUND_COUNT * KEY_DEPTH;
  localparam int KEY_AW   = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int KLEN_W   = 8;
  localparam int CMP_W    = (POS_W + 1 > KLEN_W) ? POS_W + 1 : KLEN_W;
  localparam int OP_W     = 3;
  localparam int RNUM_W   = 3;

  localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUND_COUNT - 1);
  localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(80);

  typedef enum logic [OP_W-1:0] {
    OP_ENCRYPT    = 3'd0,
    OP_DECRYPT    = 3'd1,
    OP_LOAD_TABLE = 3'd2,
    OP_LOAD_KEY   = 3'd3,
    OP_RESTART    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [TBL_AW-1:0] wr_index;
    logic [BYTE_W-1:0] wr_value;
    logic              rd_en;
    logic              rd_inv;
    logic [TBL_AW-1:0] rd_addr;
  } subst_req_t;

  typedef struct packed {
    logic              wr_en;
    logic [KEY_AW-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [KEY_AW-1:0] rd_addr;
  } key_req_t;

  // Round r, position p lives at entry r*KEY_DEPTH+p.
  function automatic logic [KEY_AW-1:0] key_addr(logic [RND_W-1:0] rnd,
                                                 logic [POS_W-1:0] pos);
    logic [KEY_AW-1:0] base;
    base = KEY_AW'(rnd) * KEY_AW'(KEY_DEPTH);
    return base + KEY_AW'(pos);
  endfunction

endpackage

@@ hw/rtl/xsbc_if.sv @@
interface xsbc_in_if import xsbc_pkg::*; ();
  logic                valid;
  logic                ready;
  op_t                 opcode;
  logic [BYTE_W-1:0]   data_byte;
  logic [TBL_AW-1:0]   table_index;
  logic [RNUM_W-1:0]   round_number;
  logic [6:0]          key_position;

  modport source(output valid, opcode, data_byte, table_index, round_number,
                 key_position, input ready);
  modport sink(input valid, opcode, data_byte, table_index, round_number,
               key_position, output ready);
endinterface

interface xsbc_out_if import xsbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] result_byte;

  modport source(output valid, result_byte, input ready);
  modport sink(input valid, result_byte, output ready);
endinterface

@@ hw/rtl/xsbc_subst_mem.sv @@
module xsbc_subst_mem import xsbc_pkg::*; (
  input  logic              clk,
  input  subst_req_t        req,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] fwd_mem [TBL_DEPTH];
  logic [TBL_AW-1:0] inv_mem [TBL_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // Loading an entry writes both directions of the table in the same cycle.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      fwd_mem[req.wr_index] <= req.wr_value;
      inv_mem[req.wr_value] <= req.wr_index;
    end
    if (req.rd_en) begin
      rd_data_r <= req.rd_inv ? inv_mem[req.rd_addr] : fwd_mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/xsbc_key_mem.sv @@
module xsbc_key_mem import xsbc_pkg::*; (
  input  logic              clk,
  input  key_req_t          req,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] key_mem [KEY_WORDS];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      key_mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= key_mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/xor_substitution_byte_cipher_core.sv @@
// Encrypt and decrypt each pass the byte through a chain of five dependent
// lookups in the registered substitution memory, with a key read per round; the
// core accepts a new beat only when idle, once the last result has gone to the
// output register. Table load, key load and restart complete while idle, no result.
// Synchronous active-low reset clears the state machine, the output valid, the
// stream position and loads a key length of 80; tables and keys stay undefined.
module xor_substitution_byte_cipher_core import xsbc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [KLEN_W-1:0] cfg_wr_data,
  xsbc_in_if.sink           in_ch,
  xsbc_out_if.source        out_ch
);

  state_t            state_r, state_nxt;
  logic              dec_r, dec_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic [RND_W-1:0]  cnt_r, cnt_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [KLEN_W-1:0] klen_r;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;

  subst_req_t        sreq;
  key_req_t          kreq;
  logic [BYTE_W-1:0] s_rd;
  logic [BYTE_W-1:0] k_rd;
  logic [BYTE_W-1:0] round_in;
  logic [BYTE_W-1:0] x;
  logic              out_free;
  logic              finish;
  logic [BYTE_W-1:0] finish_data;
  logic [CMP_W-1:0]  eff_len;
  logic [CMP_W-1:0]  pos_inc;
  logic [POS_W-1:0]  pos_adv;

  xsbc_subst_mem u_subst (
    .clk     (clk),
    .req     (sreq),
    .rd_data (s_rd)
  );

  xsbc_key_mem u_key (
    .clk     (clk),
    .req     (kreq),
    .rd_data (k_rd)
  );

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_byte = out_data_r;
  assign out_free           = !out_valid_r || out_ch.ready;

  // A length of zero acts as one; a length beyond the key depth is clamped.
  always_comb begin
    if (klen_r == '0) begin
      eff_len = CMP_W'(1);
    end else if (CMP_W'(klen_r) > CMP_W'(KEY_DEPTH)) begin
      eff_len = CMP_W'(KEY_DEPTH);
    end else begin
      eff_len = CMP_W'(klen_r);
    end
    pos_inc = CMP_W'(pos_r) + CMP_W'(1);
    pos_adv = (pos_inc >= eff_len) ? '0 : pos_inc[POS_W-1:0];
  end

  // Encrypt XORs the key before the lookup; decrypt XORs after the inverse lookup.
  assign round_in = (!dec_r && cnt_r == '0) ? data_r : s_rd;
  assign x        = round_in ^ k_rd;

  always_comb begin
    state_nxt   = state_r;
    dec_nxt     = dec_r;
    data_nxt    = data_r;
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    sreq        = '0;
    kreq        = '0;
    finish      = 1'b0;
    finish_data = s_rd;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.opcode)
            OP_ENCRYPT: begin
              kreq.rd_en   = 1'b1;
              kreq.rd_addr = key_addr('0, pos_r);
              data_nxt     = in_ch.data_byte;
              dec_nxt      = 1'b0;
              cnt_nxt      = '0;
              state_nxt    = ST_RUN;
            end
            OP_DECRYPT: begin
              kreq.rd_en   = 1'b1;
              kreq.rd_addr = key_addr(LAST_ROUND, pos_r);
              sreq.rd_en   = 1'b1;
              sreq.rd_inv  = 1'b1;
              sreq.rd_addr = in_ch.data_byte;
              data_nxt     = in_ch.data_byte;
              dec_nxt      = 1'b1;
              cnt_nxt      = '0;
              state_nxt    = ST_RUN;
            end
            OP_LOAD_TABLE: begin
              sreq.wr_en    = 1'b1;
              sreq.wr_index = in_ch.table_index;
              sreq.wr_value = in_ch.data_byte;
            end
            OP_LOAD_KEY: begin
              if (int'(in_ch.round_number) < ROUND_COUNT) begin
                kreq.wr_en   = 1'b1;
                kreq.wr_addr = key_addr(RND_W'(in_ch.round_number),
                                        POS_W'(in_ch.key_position));
                kreq.wr_data = in_ch.data_byte;
              end
            end
            OP_RESTART: begin
              pos_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_RUN: begin
        if (!dec_r) begin
          sreq.rd_en   = 1'b1;
          sreq.rd_addr = x;
          if (cnt_r == LAST_ROUND) begin
            state_nxt = ST_FIN;
          end else begin
            kreq.rd_en   = 1'b1;
            kreq.rd_addr = key_addr(cnt_r + RND_W'(1), pos_r);
            cnt_nxt      = cnt_r + RND_W'(1);
          end
        end else if (cnt_r == LAST_ROUND) begin
          // The last decrypt round ends on the XOR; wait here if the output is full.
          if (out_free) begin
            finish      = 1'b1;
            finish_data = x;
            state_nxt   = ST_IDLE;
          end
        end else begin
          sreq.rd_en   = 1'b1;
          sreq.rd_inv  = 1'b1;
          sreq.rd_addr = x;
          kreq.rd_en   = 1'b1;
          kreq.rd_addr = key_addr(LAST_ROUND - RND_W'(1) - cnt_r, pos_r);
          cnt_nxt      = cnt_r + RND_W'(1);
        end
      end

      ST_FIN: begin
        if (out_free) begin
          finish    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (finish) begin
      pos_nxt = pos_adv;
    end

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = finish_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      klen_r      <= KLEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        klen_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    dec_r      <= dec_nxt;
    data_r     <= data_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
